// ===== sv/qoi_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types and constants for the QOI-style pixel decoder.
package qoi_pkg;
  localparam int MaxLog2 = 24;
  localparam int CntW = 25;
  localparam logic [CntW-1:0] MaxPix = CntW'(1) << MaxLog2;
  localparam int CacheDepth = 64;
  localparam int CacheAw = 6;

  localparam logic [1:0] OP_DELTA = 2'd0;
  localparam logic [1:0] OP_INDEX = 2'd1;
  localparam logic [1:0] OP_SET = 2'd2;
  localparam logic [1:0] OP_RUN = 2'd3;

  // emit: a pixel beat comes out; last: that beat completes the frame
  typedef struct packed {
    logic       start;
    logic       emit;
    logic       last;
    logic [1:0] op;
    logic [CacheAw-1:0] idx;
    logic [7:0] dr;
    logic [7:0] dg;
    logic [7:0] db;
    logic [31:0] setv;
    logic [3:0] setm;
    logic [9:0] cnt;
  } cmd_t;

  function automatic logic [CacheAw-1:0] hash(input logic [31:0] p);
    logic [9:0] s;
    begin
      s = 10'(p[31:24]) * 10'd3 + 10'(p[23:16]) * 10'd5 + 10'(p[15:8]) * 10'd7
        + 10'(p[7:0]) * 10'd11;
      return s[CacheAw-1:0];
    end
  endfunction
endpackage

// ===== sv/qoi_variant_pixel_decoder_core.sv =====
`timescale 1ns / 1ps
// Top level: QOI-style pixel decoder, one compressed byte per beat.
// Path: once the byte that finishes a pixel is accepted, its command goes into the command
// queue, then the execute stage with the cache read, then the output register.
// Throughput: one byte per cycle; input stalls only when the two-entry queue is full,
// which needs a held output beat.
// Reset (rst, synchronous): pixel (0,0,0,255), cache empty, queue empty, frame_pixels 1.
module qoi_variant_pixel_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  input  logic        cfg_we,
  input  logic [24:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [9:0]  repeat_count,
  output logic        frame_done
);
  logic [qoi_pkg::CntW-1:0] fp;
  logic in_go, cmd_valid, q_full;
  qoi_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) fp <= qoi_pkg::CntW'(1);
    else if (cfg_we) begin
      if (cfg_data == '0) fp <= qoi_pkg::CntW'(1);
      else if (cfg_data > qoi_pkg::MaxPix) fp <= qoi_pkg::MaxPix;
      else fp <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign in_go = in_valid && !in_stall;

  qoi_front u_front (
    .clk(clk), .rst(rst), .in_go(in_go), .data_byte(data_byte),
    .frame_start(frame_start), .fp(fp), .cmd_valid(cmd_valid), .cmd(cmd)
  );

  qoi_back u_back (
    .clk(clk), .rst(rst), .push(in_go && cmd_valid), .din(cmd), .full(q_full),
    .out_stall(out_stall), .out_valid(out_valid),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .repeat_count(repeat_count), .frame_done(frame_done)
  );
endmodule

// ===== sv/qoi_front.sv =====
`timescale 1ns / 1ps
// Front end: opcode parsing, operand assembly and frame pixel count into commands.
module qoi_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_go,
  input  logic [7:0]         data_byte,
  input  logic               frame_start,
  input  logic [qoi_pkg::CntW-1:0] fp,
  output logic               cmd_valid,
  output qoi_pkg::cmd_t      cmd
);
  logic [1:0] pend, pend_next;
  logic [1:0] seen, seen_next;
  logic [1:0] trip, trip_next;
  logic [23:0] buffer, buffer_next;
  logic [7:0] c;
  logic [5:0] g6;
  logic [1:0] p0;
  logic [qoi_pkg::CntW-1:0] emitted, emitted_next, emitted_base, left;
  logic [9:0] raw_cnt;
  logic pix_go;
  logic done_in;

  localparam logic [1:0] P_NONE = 2'd0;
  localparam logic [1:0] P_RGBA = 2'd1;
  localparam logic [1:0] P_RGB = 2'd2;
  localparam logic [1:0] P_LUMA = 2'd3;

  assign c = data_byte;

  always_comb begin
    p0 = frame_start ? P_NONE : pend;
    pend_next = p0;
    seen_next = frame_start ? 2'd0 : seen;
    trip_next = frame_start ? 2'd0 : trip;
    buffer_next = frame_start ? 24'd0 : buffer;
    emitted_base = frame_start ? '0 : emitted;
    done_in = emitted_base >= fp;
    g6 = buffer_next[5:0];
    pix_go = 1'b0;
    raw_cnt = 10'd1;
    cmd = '0;
    cmd.start = frame_start;
    if (!done_in) begin
      case (p0)
        P_RGBA: begin
          if (seen_next < 2'd3) begin
            buffer_next = {buffer_next[15:0], c};
            seen_next = seen_next + 2'd1;
          end else begin
            pix_go = 1'b1;
            cmd.op = qoi_pkg::OP_SET;
            cmd.setv = {buffer_next, c};
            cmd.setm = 4'hf;
            pend_next = P_NONE;
            seen_next = 2'd0;
          end
        end
        P_RGB: begin
          if (seen_next < 2'd2) begin
            buffer_next = {buffer_next[15:0], c};
            seen_next = seen_next + 2'd1;
          end else begin
            pix_go = 1'b1;
            cmd.op = qoi_pkg::OP_SET;
            cmd.setv = {buffer_next[15:0], c, 8'd0};
            cmd.setm = 4'he;
            seen_next = 2'd0;
            if (trip_next != 2'd0) trip_next = trip_next - 2'd1;
            else pend_next = P_NONE;
          end
        end
        P_LUMA: begin
          pix_go = 1'b1;
          cmd.op = qoi_pkg::OP_DELTA;
          cmd.dr = 8'(g6) + 8'd216 + 8'(c[7:4]);
          cmd.dg = 8'(g6) + 8'd224;
          cmd.db = 8'(g6) + 8'd216 + 8'(c[3:0]);
          pend_next = P_NONE;
        end
        default: begin
          buffer_next = 24'd0;
          seen_next = 2'd0;
          if (c == 8'h6a) begin
            pend_next = P_RGBA;
          end else if (c[7:2] == 6'h3f) begin
            pend_next = P_RGB;
            trip_next = c[1:0];
          end else begin
            case (c[7:6])
              2'b00: begin
                pix_go = 1'b1;
                cmd.op = qoi_pkg::OP_INDEX;
                cmd.idx = c[5:0];
              end
              2'b01: begin
                pix_go = 1'b1;
                cmd.op = qoi_pkg::OP_DELTA;
                cmd.dr = 8'(c[5:4]) + 8'd254;
                cmd.dg = 8'(c[3:2]) + 8'd254;
                cmd.db = 8'(c[1:0]) + 8'd254;
              end
              2'b10: begin
                pend_next = P_LUMA;
                buffer_next = {18'd0, c[5:0]};
              end
              default: begin
                pix_go = 1'b1;
                cmd.op = qoi_pkg::OP_RUN;
                if (c[5]) raw_cnt = (10'(c[4:0]) + 10'd2) << 5;
                else raw_cnt = 10'(c[4:0]) + 10'd1;
              end
            endcase
          end
        end
      endcase
    end
    // clip the run to the pixels left in the frame
    left = fp - emitted_base;
    cmd.cnt = (qoi_pkg::CntW'(raw_cnt) > left) ? left[9:0] : raw_cnt;
    cmd.emit = pix_go;
    cmd.last = (emitted_base + qoi_pkg::CntW'(cmd.cnt)) >= fp;
    emitted_next = pix_go ? emitted_base + qoi_pkg::CntW'(cmd.cnt) : emitted_base;
    cmd_valid = pix_go || frame_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= P_NONE;
      seen <= 2'd0;
      trip <= 2'd0;
      buffer <= 24'd0;
      emitted <= '0;
    end else if (in_go) begin
      pend <= pend_next;
      seen <= seen_next;
      trip <= trip_next;
      buffer <= buffer_next;
      emitted <= emitted_next;
    end
  end
endmodule

// ===== sv/qoi_back.sv =====
`timescale 1ns / 1ps
// Back end: command queue, pixel state, colour cache RAM and output register.
module qoi_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

module qoi_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  qoi_pkg::cmd_t      din,
  output logic               full,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic [9:0]         repeat_count,
  output logic               frame_done
);
  qoi_pkg::cmd_t q0, q1, ex;
  logic [1:0] qcount;
  logic q_valid, q_pop;
  logic ex_valid, ex_fire, we, out_full;
  logic [31:0] pix, pix_base, pix_new, rd, ram_q, fwd_data;
  logic fwd_hit;
  logic [qoi_pkg::CacheDepth-1:0] vld, vld_base;
  logic [qoi_pkg::CacheAw-1:0] h, raddr;

  assign full = qcount == 2'd2;
  assign q_valid = qcount != 2'd0;
  assign ex_fire = ex_valid && (!ex.emit || !out_full || !out_stall);
  assign q_pop = q_valid && (!ex_valid || ex_fire);
  assign raddr = q_pop ? q0.idx : ex.idx;
  assign we = ex_fire && ex.emit;
  assign rd = fwd_hit ? fwd_data : ram_q;
  assign out_valid = out_full;

  qoi_ram #(.Width(32), .Depth(qoi_pkg::CacheDepth)) u_cache (
    .clk(clk), .we(we), .waddr(h), .wdata(pix_new), .raddr(raddr), .rdata(ram_q)
  );

  always_comb begin
    pix_base = ex.start ? 32'h0000_00ff : pix;
    vld_base = ex.start ? '0 : vld;
    case (ex.op)
      qoi_pkg::OP_INDEX: pix_new = vld_base[ex.idx] ? rd : 32'd0;
      qoi_pkg::OP_DELTA: pix_new = {pix_base[31:24] + ex.dr, pix_base[23:16] + ex.dg,
                                    pix_base[15:8] + ex.db, pix_base[7:0]};
      qoi_pkg::OP_SET: pix_new = {ex.setm[3] ? ex.setv[31:24] : pix_base[31:24],
                                  ex.setm[2] ? ex.setv[23:16] : pix_base[23:16],
                                  ex.setm[1] ? ex.setv[15:8] : pix_base[15:8],
                                  ex.setm[0] ? ex.setv[7:0] : pix_base[7:0]};
      default: pix_new = pix_base;
    endcase
    h = qoi_pkg::hash(pix_new);
  end

  // two-entry queue, q0 is the head
  always_ff @(posedge clk) begin
    if (q_pop) begin
      q0 <= (qcount == 2'd2) ? q1 : din;
      if (qcount == 2'd2) q1 <= din;
    end else if (push) begin
      if (qcount == 2'd0) q0 <= din;
      else q1 <= din;
    end
    if (q_pop) ex <= q0;
  end

  always_ff @(posedge clk) begin
    // write in the same cycle as the read: take the new word
    fwd_hit <= we && (h == raddr);
    fwd_data <= pix_new;
    if (we) begin
      red <= pix_new[31:24];
      green <= pix_new[23:16];
      blue <= pix_new[15:8];
      alpha <= pix_new[7:0];
      repeat_count <= ex.cnt;
      frame_done <= ex.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= 2'd0;
      ex_valid <= 1'b0;
      pix <= 32'h0000_00ff;
      vld <= '0;
      out_full <= 1'b0;
    end else begin
      qcount <= qcount + {1'b0, push} - {1'b0, q_pop};
      if (q_pop) ex_valid <= 1'b1;
      else if (ex_fire) ex_valid <= 1'b0;
      if (ex_fire) begin
        pix <= pix_new;
        vld <= ex.emit ? (vld_base | (qoi_pkg::CacheDepth'(1) << h)) : vld_base;
      end
      if (we) out_full <= 1'b1;
      else if (!out_stall) out_full <= 1'b0;
    end
  end
endmodule
